[rtl/wvu_pkg.sv]
// ----------------------------------------------------------------------------
// wvu_pkg
// Shared types and constants of the wave vertex 2x upsampler.
// ----------------------------------------------------------------------------
package wvu_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned INDEX_W    = $clog2(MAX_POINTS);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(512);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_POINTS);
  localparam logic [COUNT_W-1:0] COUNT_MIN   = COUNT_W'(1);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result steps of one request, in output order.
  localparam int unsigned STEP_N        = 5;
  localparam int unsigned STEP_OLD_COPY = 0;
  localparam int unsigned STEP_OLD_MID  = 1;
  localparam int unsigned STEP_PREV_COPY = 2;
  localparam int unsigned STEP_PREV_MID = 3;
  localparam int unsigned STEP_CUR_COPY = 4;

  // Midpoint arithmetic: q = floor(floor((num + 20) / 8) / 5), the last
  // division done by a reciprocal multiply with one correction step.
  localparam int unsigned NUM_W       = 22;
  localparam int unsigned U_W         = 20;
  localparam int unsigned RECIP_W     = 22;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned PROD_W      = U_W + RECIP_W;
  localparam int unsigned Q_W         = PROD_W - RECIP_SHIFT;

  localparam logic signed [NUM_W-1:0] ROUND_BIAS = NUM_W'(20);
  localparam logic signed [NUM_W-1:0] U_OFFSET   = NUM_W'(5 * 65536);
  localparam logic [RECIP_W-1:0]      RECIP_5    = RECIP_W'((1 << RECIP_SHIFT) / 5);
  localparam logic signed [Q_W:0]     Q_OFFSET   = (Q_W + 1)'(65536);
  localparam logic signed [Q_W:0]     SAT_MAX    = (Q_W + 1)'(32767);
  localparam logic signed [Q_W:0]     SAT_MIN    = -(Q_W + 1)'(32768);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vtx_t;

  typedef struct packed {
    vtx_t h2;
    vtx_t h1;
    vtx_t h0;
    vtx_t cur;
    logic pair;
    logic tail;
    logic last;
  } job_t;

  typedef struct packed {
    logic is_mid;
    logic eow;
    logic lor;
  } flags_t;

endpackage

[rtl/wvu_front.sv]
// ----------------------------------------------------------------------------
// wvu_front
// Accepts vertices, keeps the wave history and position, and turns each
// vertex from the third on, and a wave's last, into a request for the result sequencer.
// ----------------------------------------------------------------------------
module wvu_front
  import wvu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [COUNT_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  output logic                      q_push,
  output job_t                      q_data,
  input  logic                      q_full
);

  logic [COUNT_W-1:0] sample_count;
  logic [INDEX_W-1:0] vertex_index;
  vtx_t               h0;
  vtx_t               h1;
  vtx_t               h2;

  logic [COUNT_W-1:0] n_eff;
  logic               accept;
  logic               last;
  logic               first;
  vtx_t               cur;
  vtx_t               s0;
  vtx_t               s1;
  vtx_t               s2;

  always_comb begin
    if (sample_count < COUNT_MIN) begin
      n_eff = COUNT_MIN;
    end else if (sample_count > COUNT_MAX) begin
      n_eff = COUNT_MAX;
    end else begin
      n_eff = sample_count;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cur.x    = in_x;
  assign cur.y    = in_y;
  assign first    = (vertex_index == '0);
  assign last     = (COUNT_W'(vertex_index) >= (n_eff - COUNT_MIN));

  // The first vertex of a wave fills the whole history.
  assign s0 = first ? cur : h0;
  assign s1 = first ? cur : h1;
  assign s2 = first ? cur : h2;

  always_comb begin
    q_data.h2   = s2;
    q_data.h1   = s1;
    q_data.h0   = s0;
    q_data.cur  = cur;
    q_data.pair = (vertex_index >= INDEX_W'(2));
    q_data.tail = last && !first;
    q_data.last = last;
  end

  assign q_push = accept && (q_data.pair || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= COUNT_RESET;
    end else if (cfg_write) begin
      sample_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_index <= '0;
      h0           <= '0;
      h1           <= '0;
      h2           <= '0;
    end else if (accept) begin
      vertex_index <= last ? '0 : vertex_index + INDEX_W'(1);
      h0           <= cur;
      h1           <= s0;
      h2           <= s1;
    end
  end

  a_last_wraps : assert property (@(posedge clk) disable iff (rst)
    accept && last |=> vertex_index == '0)
    else $error("vertex index did not return to zero after the last vertex");

  a_no_push_full : assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("request pushed into a full queue");

endmodule

[rtl/wvu_queue.sv]
// ----------------------------------------------------------------------------
// wvu_queue
// Short register queue of requests between the front and the sequencer.
// ----------------------------------------------------------------------------
module wvu_queue
  import wvu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t data
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign data    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond its depth");

  a_count_track : assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + QCNT_W'(1))
    else $error("queue count did not follow a push");

endmodule

[rtl/wvu_back.sv]
// ----------------------------------------------------------------------------
// wvu_back
// Walks the result steps of each request and runs the midpoint filter in
// a four-stage pipeline that ends in the output register.
// ----------------------------------------------------------------------------
module wvu_back
  import wvu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  job_t                      q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic                      is_midpoint,
  output logic                      end_of_wave,
  output logic                      last_of_run
);

  function automatic logic signed [NUM_W-1:0] mid_num(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b,
    input logic signed [COORD_W-1:0] c,
    input logic signed [COORD_W-1:0] d
  );
    logic signed [NUM_W-1:0] s_bc;
    logic signed [NUM_W-1:0] s_ad;
    s_bc = NUM_W'(b) + NUM_W'(c);
    s_ad = NUM_W'(a) + NUM_W'(d);
    return (s_bc <<< 4) + (s_bc <<< 2) + (s_bc <<< 1) + s_bc - ((s_ad <<< 1) + s_ad);
  endfunction

  function automatic logic [U_W-1:0] mid_prep(input logic signed [NUM_W-1:0] num);
    logic signed [NUM_W-1:0] m;
    m = (num + ROUND_BIAS) >>> 3;
    return U_W'(m + U_OFFSET);
  endfunction

  function automatic logic signed [COORD_W-1:0] mid_finish(
    input logic [U_W-1:0]    u,
    input logic [PROD_W-1:0] prod
  );
    logic [Q_W-1:0]       q0;
    logic [U_W-1:0]       rem;
    logic [Q_W-1:0]       q;
    logic signed [Q_W:0]  qs;
    logic signed [COORD_W-1:0] res;
    q0  = prod[PROD_W-1:RECIP_SHIFT];
    rem = u - (U_W'(q0) * U_W'(5));
    q   = (rem >= U_W'(5)) ? q0 + Q_W'(1) : q0;
    qs  = $signed({1'b0, q}) - Q_OFFSET;
    if (qs > SAT_MAX) begin
      res = COORD_W'(SAT_MAX);
    end else if (qs < SAT_MIN) begin
      res = COORD_W'(SAT_MIN);
    end else begin
      res = COORD_W'(qs);
    end
    return res;
  endfunction

  job_t              job;
  logic              job_valid;
  logic [STEP_N-1:0] mask;
  logic [STEP_N-1:0] pick;
  logic [STEP_N-1:0] rest;
  logic [STEP_N-1:0] init_mask;
  logic              advance;
  logic              issue;
  vtx_t              op_a;
  vtx_t              op_b;
  vtx_t              op_c;
  vtx_t              op_d;
  flags_t            iss_flags;

  logic   s1_valid;
  vtx_t   s1_a;
  vtx_t   s1_b;
  vtx_t   s1_c;
  vtx_t   s1_d;
  flags_t s1_flags;

  logic                    s2_valid;
  logic signed [NUM_W-1:0] s2_num_x;
  logic signed [NUM_W-1:0] s2_num_y;
  vtx_t                    s2_b;
  flags_t                  s2_flags;

  logic              s3_valid;
  logic [U_W-1:0]    s3_u_x;
  logic [U_W-1:0]    s3_u_y;
  logic [PROD_W-1:0] s3_prod_x;
  logic [PROD_W-1:0] s3_prod_y;
  vtx_t              s3_b;
  flags_t            s3_flags;

  logic [U_W-1:0] u_x;
  logic [U_W-1:0] u_y;

  assign advance = !out_valid || !out_stall;
  assign pick    = mask & (~mask + STEP_N'(1));
  assign rest    = mask & ~pick;
  assign issue   = job_valid && advance;
  assign q_pop   = q_valid && (!job_valid || (advance && (rest == '0)));

  always_comb begin
    init_mask                 = '0;
    init_mask[STEP_OLD_COPY]  = q_data.pair;
    init_mask[STEP_OLD_MID]   = q_data.pair;
    init_mask[STEP_PREV_COPY] = q_data.tail;
    init_mask[STEP_PREV_MID]  = q_data.tail;
    init_mask[STEP_CUR_COPY]  = q_data.last;
  end

  always_comb begin
    if (pick[STEP_OLD_COPY] || pick[STEP_OLD_MID]) begin
      op_a = job.h2;
      op_b = job.h1;
      op_c = job.h0;
      op_d = job.cur;
    end else if (pick[STEP_PREV_COPY] || pick[STEP_PREV_MID]) begin
      op_a = job.h1;
      op_b = job.h0;
      op_c = job.cur;
      op_d = job.cur;
    end else begin
      op_a = job.cur;
      op_b = job.cur;
      op_c = job.cur;
      op_d = job.cur;
    end
    iss_flags.is_mid = pick[STEP_OLD_MID] || pick[STEP_PREV_MID];
    iss_flags.eow    = pick[STEP_CUR_COPY];
    iss_flags.lor    = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      mask      <= '0;
    end else if (q_pop) begin
      job_valid <= 1'b1;
      mask      <= init_mask;
    end else if (issue) begin
      job_valid <= (rest != '0);
      mask      <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
    end
  end

  assign u_x = mid_prep(s2_num_x);
  assign u_y = mid_prep(s2_num_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_a     <= op_a;
      s1_b     <= op_b;
      s1_c     <= op_c;
      s1_d     <= op_d;
      s1_flags <= iss_flags;

      s2_num_x <= mid_num(s1_a.x, s1_b.x, s1_c.x, s1_d.x);
      s2_num_y <= mid_num(s1_a.y, s1_b.y, s1_c.y, s1_d.y);
      s2_b     <= s1_b;
      s2_flags <= s1_flags;

      s3_u_x    <= u_x;
      s3_u_y    <= u_y;
      s3_prod_x <= PROD_W'(u_x) * PROD_W'(RECIP_5);
      s3_prod_y <= PROD_W'(u_y) * PROD_W'(RECIP_5);
      s3_b      <= s2_b;
      s3_flags  <= s2_flags;

      out_x       <= s3_flags.is_mid ? mid_finish(s3_u_x, s3_prod_x) : s3_b.x;
      out_y       <= s3_flags.is_mid ? mid_finish(s3_u_y, s3_prod_y) : s3_b.y;
      is_midpoint <= s3_flags.is_mid;
      end_of_wave <= s3_flags.eow;
      last_of_run <= s3_flags.lor;
    end
  end

  a_job_has_steps : assert property (@(posedge clk) disable iff (rst)
    job_valid |-> mask != '0)
    else $error("active request has no result steps left");

  a_eow_closes_run : assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_wave |-> last_of_run && !is_midpoint)
    else $error("end of wave on a result that does not close its run");

endmodule

[rtl/wave_vertex_upsample_2x.sv]
// ----------------------------------------------------------------------------
// wave_vertex_upsample_2x
// Streaming 2x upsampler for a wave of 2-D vertices with a four-tap filter.
// ----------------------------------------------------------------------------
// Each request carries one vertex; a wave of sample_count vertices yields
// twice that number less one results, each copied vertex followed by a
// filtered midpoint, and the final vertex of a wave flushes the last results.
// The output channel delivers one result per cycle while out_stall is low;
// a request yields two results, or up to five for the final vertex of a wave.
// A four-entry request queue lets vertices be taken in consecutive cycles
// until it fills; each issued step passes through s1, s2 and s3 into the
// output register. Write sample_count only while the block is idle.
module wave_vertex_upsample_2x
  import wvu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [COUNT_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic                      is_midpoint,
  output logic                      end_of_wave,
  output logic                      last_of_run
);

  logic push;
  job_t push_data;
  logic full;
  logic pop;
  logic q_valid;
  job_t q_data;

  wvu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_x     (in_x),
    .in_y     (in_y),
    .q_push   (push),
    .q_data   (push_data),
    .q_full   (full)
  );

  wvu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .valid    (q_valid),
    .data     (q_data)
  );

  wvu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .is_midpoint(is_midpoint),
    .end_of_wave(end_of_wave),
    .last_of_run(last_of_run)
  );

endmodule
